// ----- rtl/tbt_pkg.sv -----
// Shared constants and types for the thermistor beta-equation temperature block.
// No dependencies; imported by the top level.
`default_nettype none

package tbt_pkg;

  // Number of Celsius readings kept for the running mean.
  localparam int HISTORY_DEPTH = 3;
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W         = 18 + CNT_W;

  // Configuration port.
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T0      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA    = 8'd3;

  typedef logic signed [17:0] centi_t;

  localparam centi_t ABS_ZERO_C    = -18'sd27315;
  localparam centi_t ABS_ZERO_F    = -18'sd45967;
  localparam centi_t CELSIUS_MAX   = 18'sd65535;
  localparam centi_t VALID_LIMIT   = -18'sd27300;
  localparam centi_t FAHR_OFFSET   = 18'sd3200;

  localparam logic [16:0] KELVIN_OFFSET = 17'd27315;
  localparam logic [63:0] LN2_Q30       = 64'd744261118;
  localparam logic [63:0] TK_NUMERATOR  = 64'd10000 << 48;
  localparam logic [63:0] TK_LIMIT      = 64'd92850;
  localparam logic [6:0]  TB_NUMERATOR  = 7'd100;

  // Iteration counts of the shared divider for each kind of quotient.
  localparam logic [6:0] N_TERM_A = 7'd53;
  localparam logic [6:0] N_TERM_B = 7'd55;
  localparam logic [6:0] N_TK     = 7'd64;
  localparam logic [6:0] N_SMALL  = 7'd24;

endpackage

`default_nettype wire

// ----- rtl/thermistor_beta_temperature.sv -----
// Thermistor temperature from a divider ADC sample using the beta equation.
// Steps per item: multiply, then normalize and square for each of the two logs, a serial
// multiply by ln 2, divisions for term A, term B and kelvin, history update, mean division
// for a nonempty history, Fahrenheit divisions when asked for, and output. A flagged sample
// or a zero register goes straight from the multiply to the history update.
// One item at a time: the next beat is taken only after the result is posted.
// Synchronous active-high reset clears control and fills history with -273.15 C.
`default_nettype none

module thermistor_beta_temperature (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Configuration write channel.
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [tbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tbt_pkg::CFG_DAT_W-1:0]  cfg_data,
  // Input stream.
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  input  wire logic [15:0]                    s_tdata,   // [9:0] adc_sample
  input  wire logic                           s_tuser,   // [0] mode (1 = Fahrenheit)
  // Result stream.
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  output      logic [39:0]                    m_tdata,   // [17:0] temperature_centi,
                                                         // [35:18] average_centi
  output      logic [1:0]                     m_tuser    // [0] sample_out_of_range,
                                                         // [1] average_valid
);

  import tbt_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_NORM  = 4'd2;
  localparam logic [3:0] S_SQR   = 4'd3;
  localparam logic [3:0] S_LNMUL = 4'd4;
  localparam logic [3:0] S_DIVA  = 4'd5;
  localparam logic [3:0] S_DIVB  = 4'd6;
  localparam logic [3:0] S_DIVT  = 4'd7;
  localparam logic [3:0] S_HIST  = 4'd8;
  localparam logic [3:0] S_DIVM  = 4'd9;
  localparam logic [3:0] S_FT    = 4'd10;
  localparam logic [3:0] S_FM    = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state;

  // Configuration registers.
  logic [15:0]        series_ohm;
  logic [15:0]        nominal_ohm;
  logic signed [14:0] nominal_t0;
  logic [15:0]        beta;

  // Item registers.
  logic [9:0]  sample;
  logic        fahr;
  logic [25:0] den_prod;
  logic        sel_den;

  // Logarithm unit: normalize by single-bit shifts, then one squaring per bit.
  logic [31:0] y;
  logic [4:0]  k;
  logic [27:0] frac;
  logic [4:0]  lcnt;
  logic [32:0] ln_num;

  // Serial multiply by ln 2, one bit of the log difference per cycle.
  logic        neg;
  logic [32:0] mag;
  logic [63:0] acc;
  logic [5:0]  mcnt;

  // Shared restoring divider, one quotient bit per cycle.
  logic [63:0] dq;
  logic [56:0] rem;
  logic [55:0] dv;
  logic [6:0]  dcnt;

  logic [55:0] term_a;

  // History and results.
  centi_t             hist [HISTORY_DEPTH];
  centi_t             celsius;
  centi_t             mean;
  logic               sum_neg;
  logic [CNT_W-1:0]   cnt;
  centi_t             res_t;
  centi_t             res_a;

  // ---------------------------------------------------------------------
  // Combinational helpers.
  // ---------------------------------------------------------------------
  logic [25:0] num_prod, den_prod_w;
  logic        special;
  logic [63:0] sq;
  logic [32:0] sq_hi;
  logic        sq_bit;
  logic [31:0] y_sq;
  logic [27:0] frac_next;
  logic [32:0] log_res;
  logic [63:0] acc_next;
  logic [56:0] rem_sh;
  logic        div_ge;
  logic [56:0] rem_next;
  logic [63:0] dq_next;
  logic        div_last;
  logic [16:0] t0_kelvin;
  logic [55:0] tb;
  logic [55:0] inv_sum, inv_diff;
  logic [17:0] q18;
  centi_t             ent [HISTORY_DEPTH];
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]   count;
  logic [SUM_W-1:0]   sum_mag;
  logic [23:0]        mean_dividend;
  logic [23:0]        fahr_c_dividend, fahr_m_dividend;

  // |v * 9| + 2, the rounding numerator of a Celsius to Fahrenheit step.
  function automatic logic [23:0] fahr_num(input centi_t v);
    logic signed [21:0] p;
    logic [21:0]        m;
    p = ($signed({{4{v[17]}}, v}) <<< 3) + $signed({{4{v[17]}}, v});
    m = p[21] ? 22'(-p) : 22'(p);
    return {2'b00, m} + 24'd2;
  endfunction

  always_comb begin
    num_prod   = {10'b0, series_ohm} * {16'b0, sample};
    den_prod_w = {10'b0, nominal_ohm} * {16'b0, 10'd1023 - sample};
    special    = (sample == 10'd0) || (sample == 10'd1023) || (series_ohm == 16'd0) ||
                 (nominal_ohm == 16'd0) || (beta == 16'd0);

    sq        = {32'b0, y} * {32'b0, y};
    sq_hi     = sq[63:31];
    sq_bit    = sq_hi[32];
    y_sq      = sq_bit ? sq_hi[32:1] : sq_hi[31:0];
    frac_next = {frac[26:0], sq_bit};
    log_res   = {k, frac_next};

    acc_next = {acc[62:0], 1'b0} + (mag[32] ? LN2_Q30 : 64'd0);

    rem_sh   = {rem[55:0], dq[63]};
    div_ge   = rem_sh >= {1'b0, dv};
    rem_next = div_ge ? rem_sh - {1'b0, dv} : rem_sh;
    dq_next  = {dq[62:0], div_ge};
    div_last = (dcnt == 7'd1);
    q18      = dq_next[17:0];

    t0_kelvin = 17'($signed({{2{nominal_t0[14]}}, nominal_t0})) + KELVIN_OFFSET;
    tb        = dq_next[55:0];
    inv_sum   = tb + term_a;
    inv_diff  = tb - term_a;

    // History after the new reading is shifted in.
    ent[0] = celsius;
    for (int i = 1; i < HISTORY_DEPTH; i++) ent[i] = hist[i-1];
    sum   = '0;
    count = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (ent[i] > VALID_LIMIT) begin
        sum   = sum + SUM_W'(ent[i]);
        count = count + CNT_W'(1);
      end
    end
    sum_mag       = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    mean_dividend = 24'(sum_mag) + 24'(count >> 1);

    fahr_c_dividend = fahr_num(celsius);
    fahr_m_dividend = fahr_num(mean);
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------
  // Sequencer and datapath registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      series_ohm  <= 16'd10000;
      nominal_ohm <= 16'd10000;
      nominal_t0  <= 15'sd2500;
      beta        <= 16'd3950;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] <= ABS_ZERO_C;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SERIES:  series_ohm  <= cfg_data;
          REG_NOMINAL: nominal_ohm <= cfg_data;
          REG_T0:      nominal_t0  <= $signed(cfg_data[14:0]);
          REG_BETA:    beta        <= cfg_data;
          default: ;
        endcase
      end

      // In S_OUT the output register is handled by the state itself.
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;

      // Divider steps; the last step is finished by the state that owns it.
      if ((state == S_DIVA || state == S_DIVB || state == S_DIVT ||
           state == S_DIVM || state == S_FT || state == S_FM) && !div_last) begin
        dq   <= dq_next;
        rem  <= rem_next;
        dcnt <= dcnt - 7'd1;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sample <= s_tdata[9:0];
            fahr   <= s_tuser;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          if (special) begin
            celsius <= ABS_ZERO_C;
            state   <= S_HIST;
          end else begin
            y        <= {6'b0, num_prod};
            den_prod <= den_prod_w;
            k        <= 5'd31;
            sel_den  <= 1'b0;
            state    <= S_NORM;
          end
        end
        S_NORM: begin
          if (y[31]) begin
            lcnt  <= 5'd27;
            state <= S_SQR;
          end else begin
            y <= {y[30:0], 1'b0};
            k <= k - 5'd1;
          end
        end
        S_SQR: begin
          frac <= frac_next;
          lcnt <= lcnt - 5'd1;
          if (lcnt == 5'd0) begin
            if (!sel_den) begin
              ln_num  <= log_res;
              sel_den <= 1'b1;
              y       <= {6'b0, den_prod};
              k       <= 5'd31;
              state   <= S_NORM;
            end else begin
              neg   <= ln_num < log_res;
              mag   <= (ln_num < log_res) ? log_res - ln_num : ln_num - log_res;
              acc   <= '0;
              mcnt  <= 6'd32;
              state <= S_LNMUL;
            end
          end else begin
            y <= y_sq;
          end
        end
        S_LNMUL: begin
          acc  <= acc_next;
          mag  <= {mag[31:0], 1'b0};
          mcnt <= mcnt - 6'd1;
          if (mcnt == 6'd0) begin
            // ln|x| in Q.28, scaled by 2^20, over beta.
            dq    <= {acc_next[62:30], 31'b0};
            dv    <= {40'b0, beta};
            dcnt  <= N_TERM_A;
            rem   <= '0;
            state <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (div_last) begin
            term_a <= dq_next[55:0];
            dq     <= {TB_NUMERATOR, 57'b0};
            dv     <= {39'b0, t0_kelvin};
            dcnt   <= N_TERM_B;
            rem    <= '0;
            state  <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_last) begin
            if (!neg) begin
              dq    <= TK_NUMERATOR + {9'b0, inv_sum[55:1]};
              dv    <= inv_sum;
              dcnt  <= N_TK;
              rem   <= '0;
              state <= S_DIVT;
            end else if (term_a > tb) begin
              celsius <= ABS_ZERO_C;
              state   <= S_HIST;
            end else if (term_a == tb) begin
              celsius <= CELSIUS_MAX;
              state   <= S_HIST;
            end else begin
              dq    <= TK_NUMERATOR + {9'b0, inv_diff[55:1]};
              dv    <= inv_diff;
              dcnt  <= N_TK;
              rem   <= '0;
              state <= S_DIVT;
            end
          end
        end
        S_DIVT: begin
          if (div_last) begin
            if (dq_next > TK_LIMIT) celsius <= CELSIUS_MAX;
            else celsius <= $signed(dq_next[17:0]) - $signed({1'b0, KELVIN_OFFSET});
            state <= S_HIST;
          end
        end
        S_HIST: begin
          for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] <= ent[i];
          cnt     <= count;
          sum_neg <= sum[SUM_W-1];
          mean    <= '0;
          if (count != '0) begin
            dq    <= {mean_dividend, 40'b0};
            dv    <= 56'(count);
            dcnt  <= N_SMALL;
            rem   <= '0;
            state <= S_DIVM;
          end else if (fahr) begin
            dq    <= {fahr_c_dividend, 40'b0};
            dv    <= 56'd5;
            dcnt  <= N_SMALL;
            rem   <= '0;
            state <= S_FT;
          end else begin
            res_t <= celsius;
            res_a <= '0;
            state <= S_OUT;
          end
        end
        S_DIVM: begin
          if (div_last) begin
            mean <= sum_neg ? -$signed(q18) : $signed(q18);
            if (fahr) begin
              dq    <= {fahr_c_dividend, 40'b0};
              dv    <= 56'd5;
              dcnt  <= N_SMALL;
              rem   <= '0;
              state <= S_FT;
            end else begin
              res_t <= celsius;
              res_a <= sum_neg ? -$signed(q18) : $signed(q18);
              state <= S_OUT;
            end
          end
        end
        S_FT: begin
          if (div_last) begin
            res_t <= (celsius[17] ? -$signed(q18) : $signed(q18)) + FAHR_OFFSET;
            if (cnt != '0) begin
              dq    <= {fahr_m_dividend, 40'b0};
              dv    <= 56'd5;
              dcnt  <= N_SMALL;
              rem   <= '0;
              state <= S_FM;
            end else begin
              res_a <= '0;
              state <= S_OUT;
            end
          end
        end
        S_FM: begin
          if (div_last) begin
            res_a <= (mean[17] ? -$signed(q18) : $signed(q18)) + FAHR_OFFSET;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // The output register frees up as soon as the waiting beat is taken.
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {4'b0, res_a, res_t};
            m_tuser  <= {cnt != '0, (sample == 10'd0) || (sample == 10'd1023)};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------
  // A flagged sample always reports absolute zero in the chosen scale.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> ($signed(m_tdata[17:0]) == ABS_ZERO_C ||
                                  $signed(m_tdata[17:0]) == ABS_ZERO_F))
    else $error("flagged sample without absolute-zero temperature");

  // An empty history reports a zero mean.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |-> (m_tdata[35:18] == 18'd0))
    else $error("empty history with nonzero mean");

  // Once a beat is taken in, no other is taken until the result is posted.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second beat accepted while busy");

endmodule

`default_nettype wire

// ----- test/tb_thermistor_beta_temperature.sv -----
// Self-checking testbench for thermistor_beta_temperature: drives ADC samples with
// random gaps, predicts each beat with a fixed-point beta-equation model, compares.
// Depends on rtl/tbt_pkg.sv and rtl/thermistor_beta_temperature.sv.
`timescale 1ns / 1ps

module tb_thermistor_beta_temperature;
  import tbt_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;

  typedef struct packed {
    logic [9:0] adc;
    logic       fahr;
  } sample_t;

  typedef struct packed {
    logic [17:0] temp;
    logic [17:0] avg;
    logic        oor;
    logic        avg_ok;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0] m_tuser;

  thermistor_beta_temperature dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Predictor copy of the configuration registers and the Celsius history.
  longint unsigned series_ohm, nominal_ohm, beta_k;
  longint          t0_centi;
  longint          hist_c[HISTORY_DEPTH];

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int       errors = 0;
  int       cycle = 0;
  int       n_accepted = 0;   // input beats taken, counted at the rising edge
  int       n_seen = 0;       // input beats already noticed by the driver
  bit       hold_req = 1'b0;  // asks the receiver for one long stall

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // log2 of n in unsigned Q.28, truncating at every squaring.
  function automatic longint unsigned log2_fix(longint unsigned n);
    int k;
    longint unsigned y, res;
    k = 0;
    while (k < 62 && (n >> (k + 1)) != 0) k++;
    y = n << (31 - k);
    res = longint'(k) << 28;
    for (int i = 27; i >= 0; i--) begin
      y = (y * y) >> 31;
      if (y >= (64'd2 << 31)) begin
        y >>= 1;
        res |= 64'd1 << i;
      end
    end
    return res;
  endfunction

  // Rounds to nearest, ties away from zero.
  function automatic longint div_round(longint n, longint d);
    longint unsigned m, q;
    m = n < 0 ? -n : n;
    q = (m + d / 2) / d;
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint scaled(longint c, bit fahr);
    return fahr ? div_round(c * 9, 5) + 3200 : c;
  endfunction

  function automatic longint celsius_from_adc(int unsigned a);
    longint unsigned ln_num, ln_den, mag, ln_x, term_a, term_b, inv, tk;
    bit neg;
    if (a == 0 || a >= 1023 || series_ohm == 0 || nominal_ohm == 0 || beta_k == 0)
      return -27315;
    ln_num = log2_fix(series_ohm * a);
    ln_den = log2_fix(nominal_ohm * (1023 - a));
    neg = ln_num < ln_den;
    mag = neg ? ln_den - ln_num : ln_num - ln_den;
    // The product stays below 2^64: mag < 2^33 and the constant < 2^30.
    ln_x = (mag * 64'd744261118) >> 30;
    term_a = (ln_x << 20) / beta_k;
    term_b = (64'd100 << 48) / longint'(t0_centi + 27315);
    if (!neg) begin
      inv = term_b + term_a;
    end else begin
      if (term_a > term_b) return -27315;
      if (term_a == term_b) return 65535;
      inv = term_b - term_a;
    end
    tk = ((64'd10000 << 48) + inv / 2) / inv;
    if (tk > 92850) return 65535;
    return longint'(tk) - 27315;
  endfunction

  // Advances the history and returns the reading the block should produce.
  function automatic reading_t predict_reading(sample_t s);
    reading_t r;
    longint c, sum, cnt, avg;
    c = celsius_from_adc(s.adc);
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist_c[i] = hist_c[i-1];
    hist_c[0] = c;
    sum = 0;
    cnt = 0;
    foreach (hist_c[i]) begin
      if (hist_c[i] > -27300) begin
        sum += hist_c[i];
        cnt++;
      end
    end
    avg = cnt != 0 ? scaled(div_round(sum, cnt), s.fahr) : 0;
    r.temp = 18'(scaled(c, s.fahr));
    r.avg = 18'(avg);
    r.oor = (s.adc == 0 || s.adc == 1023);
    r.avg_ok = cnt != 0;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Driver: offers queued samples; a gap follows each accepted beat.
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (n_seen != n_accepted) begin
        n_seen = n_accepted;
        send_gap = gap_len();
      end
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, pending_samples[0].adc};
        s_tuser <= pending_samples[0].fahr;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Each accepted beat leaves the queue and is predicted at the accepting edge.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_readings.push_back(predict_reading(pending_samples.pop_front()));
      n_accepted++;
    end
  end

  // Receiver readiness, with random stalls and an occasional long hold-off.
  int recv_gap = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0) recv_gap = gap_len();
    end
  end

  // Monitor: checks every result beat against the oldest prediction.
  always @(posedge clk) begin
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_readings.size() == 0) begin
        $error("result beat with no reading expected");
        errors++;
      end else begin
        want = expected_readings.pop_front();
        if (m_tdata[17:0] !== want.temp) begin
          $error("temperature_centi expected %0d got %0d",
                 $signed(want.temp), $signed(m_tdata[17:0]));
          errors++;
        end
        if (m_tdata[35:18] !== want.avg) begin
          $error("average_centi expected %0d got %0d",
                 $signed(want.avg), $signed(m_tdata[35:18]));
          errors++;
        end
        if (m_tuser[0] !== want.oor) begin
          $error("sample_out_of_range expected %0b got %0b", want.oor, m_tuser[0]);
          errors++;
        end
        if (m_tuser[1] !== want.avg_ok) begin
          $error("average_valid expected %0b got %0b", want.avg_ok, m_tuser[1]);
          errors++;
        end
      end
    end
  end

  task automatic queue_sample(int a, bit f);
    sample_t s;
    s.adc = a[9:0];
    s.fahr = f;
    pending_samples.push_back(s);
  endtask

  // Waits until the block has drained, then a little longer so it is idle.
  task automatic drain();
    while (pending_samples.size() > 0 || s_tvalid || expected_readings.size() > 0)
      @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SERIES:  series_ohm = val;
      REG_NOMINAL: nominal_ohm = val;
      REG_T0:      t0_centi = longint'($signed(val[14:0]));
      REG_BETA:    beta_k = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(int s, int r0, int t0, int b);
    write_reg(REG_SERIES, 16'(s));
    write_reg(REG_NOMINAL, 16'(r0));
    write_reg(REG_T0, 16'(t0));
    write_reg(REG_BETA, 16'(b));
  endtask

  // Mostly mid-scale samples, with the extremes mixed in.
  task automatic random_run(int n);
    int a;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: a = $urandom_range(0, 1) ? 0 : 1023;
        1: a = $urandom_range(1, 20);
        2: a = $urandom_range(1000, 1022);
        default: a = $urandom_range(1, 1022);
      endcase
      queue_sample(a, $urandom_range(0, 1));
    end
  endtask

  initial begin
    series_ohm = 10000;
    nominal_ohm = 10000;
    t0_centi = 2500;
    beta_k = 3950;
    foreach (hist_c[i]) hist_c[i] = -27315;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty history, flagged codes, extremes and both scales.
    queue_sample(0, 0);
    queue_sample(1023, 1);
    queue_sample(1023, 0);
    queue_sample(1, 0);
    queue_sample(1022, 1);
    queue_sample(511, 0);
    queue_sample(512, 1);
    queue_sample(341, 1);
    queue_sample(682, 0);
    queue_sample(0, 1);
    queue_sample(0, 1);
    queue_sample(0, 0);
    queue_sample(700, 1);
    drain();

    // Extreme registers: zero values, smallest and largest settings.
    configure(0, 10000, 2500, 3950);
    queue_sample(500, 0);
    queue_sample(600, 1);
    drain();
    configure(65535, 1, 15000, 1);
    queue_sample(1, 0);
    queue_sample(1022, 1);
    queue_sample(512, 0);
    drain();
    configure(1, 65535, -4000, 65535);
    queue_sample(1, 1);
    queue_sample(1022, 0);
    queue_sample(300, 1);
    drain();
    configure(10000, 0, 2500, 0);
    queue_sample(400, 0);
    drain();

    // Long receiver hold-off while the sender keeps offering samples.
    configure(10000, 10000, 2500, 3950);
    hold_req = 1'b1;
    random_run(40);
    drain();

    // Random phases across several register settings.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 0)
        configure(10000, 10000, 2500, 3950);
      else
        configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 19000) - 4000, $urandom_range(0, 65535));
      random_run(130);
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tbt_pkg.sv
rtl/thermistor_beta_temperature.sv
test/tb_thermistor_beta_temperature.sv
